// File: rtl/core/tbpg_pkg.sv
// ----------------------------------------------------------------------------
// tbpg_pkg
// Shared types and constants for the token bucket packet gate.
// ----------------------------------------------------------------------------
package tbpg_pkg;

    localparam int AMOUNT_W  = 32;
    localparam int BITS_W    = 19;
    localparam int CPP_W     = 16;
    localparam int CPB_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = CPB_W + BITS_W;
    localparam int COST_W    = PROD_W - FRAC_W + 1;
    localparam int LEFT_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COST_PER_PACKET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_PER_BIT_Q16 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_ENABLE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TOKENS   = 3'd4;

    // Operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_OFFER = 1'b1;

    typedef struct packed {
        logic                op;
        logic [AMOUNT_W-1:0] token_amount;
        logic [BITS_W-1:0]   packet_bits;
    } t_in_item;

    typedef struct packed {
        logic              granted;
        logic              depleted_event;
        logic [LEFT_W-1:0] tokens_left;
    } t_out_item;

    // Configuration seen by the front and back parts
    typedef struct packed {
        logic [CPP_W-1:0]  cost_per_packet;
        logic [CPB_W-1:0]  cost_per_bit_q16;
        logic [CPB_W-1:0]  max_tokens;
        logic              cap_enable;
    } t_cfg;

    // Bucket load request from a write of the initial count register
    typedef struct packed {
        logic                  en;
        logic [CFG_DATA_W-1:0] value;
    } t_load;

    // Classified command passed from front to back
    typedef struct packed {
        logic                op;
        logic [AMOUNT_W-1:0] token_amount;
        logic [COST_W-1:0]   cost;
    } t_cmd;

endpackage

// File: rtl/core/tbpg_front.sv
// ----------------------------------------------------------------------------
// tbpg_front
// Accepts transactions, multiplies the packet length by the per-bit cost and
// forms the full packet cost.
// ----------------------------------------------------------------------------
module tbpg_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  tbpg_pkg::t_in_item i_item,
    input  tbpg_pkg::t_cfg     i_cfg,
    output logic               o_push,
    input  logic               i_push_ready,
    output tbpg_pkg::t_cmd     o_cmd
);

    logic                                r_s1_valid;
    logic                                r_s1_op;
    logic [tbpg_pkg::AMOUNT_W-1:0]       r_s1_amount;
    logic [tbpg_pkg::PROD_W-1:0]         r_s1_prod;
    logic                                w_take;

    assign o_ready = i_rst_n && (!r_s1_valid || i_push_ready);
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_s1_valid && i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_op     <= i_item.op;
            r_s1_amount <= i_item.token_amount;
            r_s1_prod   <= tbpg_pkg::PROD_W'(i_cfg.cost_per_bit_q16)
                         * tbpg_pkg::PROD_W'(i_item.packet_bits);
        end
    end

    always_comb begin
        o_cmd.op           = r_s1_op;
        o_cmd.token_amount = r_s1_amount;
        // Drop the fraction of the per-bit product, add the fixed charge
        o_cmd.cost = tbpg_pkg::COST_W'(r_s1_prod[tbpg_pkg::PROD_W-1:tbpg_pkg::FRAC_W])
                   + tbpg_pkg::COST_W'(i_cfg.cost_per_packet);
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !i_push_ready |=> r_s1_valid && $stable(r_s1_prod)
            && $stable(r_s1_op))
        else $error("front stage lost a stalled command");

endmodule

// File: rtl/core/tbpg_queue.sv
// ----------------------------------------------------------------------------
// tbpg_queue
// Short command queue between the front and the back part.
// ----------------------------------------------------------------------------
module tbpg_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  tbpg_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_not_empty,
    output tbpg_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tbpg_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_not_empty  = (r_count != '0);
    assign o_cmd        = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_push_ready)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("pop from an empty queue");

endmodule

// File: rtl/core/tbpg_back.sv
// ----------------------------------------------------------------------------
// tbpg_back
// Holds the bucket, applies adds and offers, and registers the result.
// ----------------------------------------------------------------------------
module tbpg_back #(
    parameter int TOKEN_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbpg_pkg::t_cfg      i_cfg,
    input  tbpg_pkg::t_load     i_load,
    input  logic                i_not_empty,
    output logic                o_pop,
    input  tbpg_pkg::t_cmd      i_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output tbpg_pkg::t_out_item o_item
);

    localparam int TW    = TOKEN_WIDTH;
    localparam int SUM_W = ((TW > tbpg_pkg::AMOUNT_W) ? TW : tbpg_pkg::AMOUNT_W) + 1;
    localparam int CMP_W = (TW > tbpg_pkg::COST_W) ? TW : tbpg_pkg::COST_W;

    logic [TW-1:0]       r_count;
    logic [TW-1:0]       n_count;
    logic                r_reported;
    logic                n_reported;
    logic                r_out_valid;
    tbpg_pkg::t_out_item r_out;
    tbpg_pkg::t_out_item n_out;

    logic [SUM_W-1:0]    w_sum;
    logic [TW-1:0]       w_sat;
    logic [TW-1:0]       w_cap;
    logic                w_covers;

    assign o_pop   = i_not_empty && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        w_sum    = SUM_W'(r_count) + SUM_W'(i_cmd.token_amount);
        w_sat    = (w_sum > SUM_W'({TW{1'b1}})) ? {TW{1'b1}} : w_sum[TW-1:0];
        w_cap    = TW'(i_cfg.max_tokens);
        w_covers = CMP_W'(r_count) >= CMP_W'(i_cmd.cost);

        n_count    = r_count;
        n_reported = r_reported;
        n_out.granted        = 1'b0;
        n_out.depleted_event = 1'b0;

        case (i_cmd.op)
            tbpg_pkg::OP_ADD: begin
                n_count    = (i_cfg.cap_enable && (w_sat >= w_cap)) ? w_cap : w_sat;
                n_reported = 1'b0;
            end
            tbpg_pkg::OP_OFFER: begin
                if (w_covers) begin
                    n_count       = r_count - TW'(i_cmd.cost);
                    n_out.granted = 1'b1;
                end else if (!r_reported) begin
                    // Report only the first refusal since the last add
                    n_reported           = 1'b1;
                    n_out.depleted_event = 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.tokens_left = tbpg_pkg::LEFT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load.en) begin
                r_count <= TW'(i_load.value);
            end else if (o_pop) begin
                r_count <= n_count;
            end
            if (o_pop) begin
                r_reported <= n_reported;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_grant_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.granted && r_out.depleted_event))
        else $error("grant and depletion reported together");

    a_single_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && r_reported && !i_load.en |=> !r_out.depleted_event)
        else $error("depletion reported twice without an add");

endmodule

// File: rtl/core/token_bucket_packet_gate_unit.sv
// ----------------------------------------------------------------------------
// token_bucket_packet_gate_unit
// Token bucket gate: grants or refuses offered packets against a token count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_item): each transaction is either a
//   token add (op = OP_ADD) or an offer of the head packet (op = OP_OFFER)
//   carrying its length in bits. Output channel (o_valid / i_ready / o_item):
//   exactly one result per input transaction, in order, with the grant, the
//   depletion event and the token count after the step.
//   Configuration: i_cfg_we / i_cfg_idx / i_cfg_wdata write one register per
//   cycle; write only while no transaction is in flight. Writing the initial
//   count register loads the bucket at once.
//   Path: from input acceptance to result valid through the multiply
//   stage, the command queue and the bucket update into the output register.
//   Throughput: one transaction per cycle while i_ready is high; the bucket
//   update is one add or compare-and-subtract; the cost multiply is pipelined.
//   Reset: synchronous, active low; clears the bucket, the depletion flag and
//   all valid flags, and loads register defaults (no cap, max all ones).
//   Stall: when i_ready is low the result holds in the output register, the
//   queue fills behind it, and o_ready drops once the queue and the multiply
//   stage are full.
// ----------------------------------------------------------------------------
module token_bucket_packet_gate_unit #(
    parameter int TOKEN_WIDTH = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  tbpg_pkg::t_in_item                    i_item,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output tbpg_pkg::t_out_item                   o_item,
    input  logic                                  i_cfg_we,
    input  logic [tbpg_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [tbpg_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    tbpg_pkg::t_cfg  r_cfg;
    tbpg_pkg::t_load w_load;
    tbpg_pkg::t_cmd  w_push_cmd;
    tbpg_pkg::t_cmd  w_head_cmd;
    logic            w_push;
    logic            w_push_ready;
    logic            w_pop;
    logic            w_not_empty;

    // Register file: unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cost_per_packet  <= '0;
            r_cfg.cost_per_bit_q16 <= '0;
            r_cfg.max_tokens       <= '1;
            r_cfg.cap_enable       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbpg_pkg::CFG_COST_PER_PACKET:
                    r_cfg.cost_per_packet <= i_cfg_wdata[tbpg_pkg::CPP_W-1:0];
                tbpg_pkg::CFG_COST_PER_BIT_Q16:
                    r_cfg.cost_per_bit_q16 <= i_cfg_wdata[tbpg_pkg::CPB_W-1:0];
                tbpg_pkg::CFG_MAX_TOKENS:
                    r_cfg.max_tokens <= i_cfg_wdata[tbpg_pkg::CPB_W-1:0];
                tbpg_pkg::CFG_CAP_ENABLE:
                    r_cfg.cap_enable <= i_cfg_wdata[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // The initial count register only matters as a load of the bucket
    assign w_load.en    = i_rst_n && i_cfg_we && (i_cfg_idx == tbpg_pkg::CFG_INITIAL_TOKENS);
    assign w_load.value = i_cfg_wdata;

    tbpg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (i_item),
        .i_cfg        (r_cfg),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_cmd        (w_push_cmd)
    );

    tbpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_cmd        (w_push_cmd),
        .i_pop        (w_pop),
        .o_not_empty  (w_not_empty),
        .o_cmd        (w_head_cmd)
    );

    tbpg_back #(
        .TOKEN_WIDTH (TOKEN_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_load      (w_load),
        .i_not_empty (w_not_empty),
        .o_pop       (w_pop),
        .i_cmd       (w_head_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule
